@@ rtl/uart_rx_tx_ring_buffers_top_assert.svh @@
// Assertion macros shared by the ring buffer block.
`ifndef UART_RX_TX_RING_BUFFERS_TOP_ASSERT_SVH
`define UART_RX_TX_RING_BUFFERS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UARTRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UARTRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/uartrb_pkg.sv @@
`timescale 1ns / 1ps

package uartrb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  // The receive count wraps before it reaches the depth; the transmit count
  // can equal the depth.
  localparam int RX_CW = $clog2(RX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  localparam int BYTE_W      = 8;
  localparam int ERR_W       = 3;
  localparam int RX_LEVEL_W  = 6;
  localparam int TX_LEVEL_W  = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    CMD_RX_BYTE  = 2'd0,
    CMD_TX_READY = 2'd1,
    CMD_HOST_WR  = 2'd2,
    CMD_HOST_RD  = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_WR_FULL  = 2'd1,
    ST_RD_EMPTY = 2'd2,
    ST_DROP     = 2'd3
  } status_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [RX_AW-1:0]  addr;
    logic [BYTE_W-1:0] wdata;
  } rx_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [TX_AW-1:0]  addr;
    logic [BYTE_W-1:0] wdata;
  } tx_req_t;

  // Everything about a response except the bytes that come from memory.
  typedef struct packed {
    logic                  tx_valid;
    logic                  tx_from_mem;
    logic [BYTE_W-1:0]     tx_byte;
    logic                  read_valid;
    status_t               status;
    logic                  rx_overflow;
    logic [RX_LEVEL_W-1:0] rx_level;
    logic [TX_LEVEL_W-1:0] tx_level;
    logic                  rx_available;
  } resp_t;

endpackage

@@ rtl/uartrb_ram.sv @@
`timescale 1ns / 1ps

module uartrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/uartrb_ctrl.sv @@
`timescale 1ns / 1ps

module uartrb_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  uartrb_pkg::cmd_e_t                cmd,
  input  logic [uartrb_pkg::BYTE_W-1:0]     byte_in,
  input  logic [uartrb_pkg::ERR_W-1:0]      line_errors,
  input  logic                              dre_empty,
  output uartrb_pkg::rx_req_t               rx_req,
  output uartrb_pkg::tx_req_t               tx_req,
  output uartrb_pkg::resp_t                 resp
);

  localparam logic [uartrb_pkg::RX_AW-1:0] RX_LAST =
    uartrb_pkg::RX_AW'(uartrb_pkg::RX_DEPTH - 1);
  localparam logic [uartrb_pkg::TX_AW-1:0] TX_LAST =
    uartrb_pkg::TX_AW'(uartrb_pkg::TX_DEPTH - 1);
  localparam logic [uartrb_pkg::RX_CW-1:0] RX_CNT_TOP =
    uartrb_pkg::RX_CW'(uartrb_pkg::RX_DEPTH - 1);
  localparam logic [uartrb_pkg::TX_CW-1:0] TX_CNT_FULL =
    uartrb_pkg::TX_CW'(uartrb_pkg::TX_DEPTH);

  logic [uartrb_pkg::RX_AW-1:0] rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt;
  logic [uartrb_pkg::TX_AW-1:0] tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt;
  logic [uartrb_pkg::RX_CW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [uartrb_pkg::TX_CW-1:0] tx_cnt_r, tx_cnt_nxt;
  logic                         ovf_r, ovf_nxt;

  always_comb begin
    rx_wp_nxt  = rx_wp_r;
    rx_rp_nxt  = rx_rp_r;
    tx_wp_nxt  = tx_wp_r;
    tx_rp_nxt  = tx_rp_r;
    rx_cnt_nxt = rx_cnt_r;
    tx_cnt_nxt = tx_cnt_r;
    ovf_nxt    = ovf_r;
    rx_req     = '0;
    tx_req     = '0;
    resp       = '0;
    resp.status = uartrb_pkg::ST_OK;

    unique case (cmd)
      uartrb_pkg::CMD_RX_BYTE: begin
        if (line_errors != '0) begin
          resp.status = uartrb_pkg::ST_DROP;
        end else begin
          rx_req.we    = 1'b1;
          rx_req.addr  = rx_wp_r;
          rx_req.wdata = byte_in;
          rx_wp_nxt    = (rx_wp_r == RX_LAST) ? '0 : rx_wp_r + 1'b1;
          // Reaching the depth empties the count and leaves the bytes behind.
          if (rx_cnt_r == RX_CNT_TOP) begin
            rx_cnt_nxt = '0;
            ovf_nxt    = 1'b1;
          end else begin
            rx_cnt_nxt = rx_cnt_r + 1'b1;
          end
        end
      end
      uartrb_pkg::CMD_TX_READY: begin
        if (tx_cnt_r != '0) begin
          tx_req.re        = 1'b1;
          tx_req.addr      = tx_rp_r;
          tx_rp_nxt        = (tx_rp_r == TX_LAST) ? '0 : tx_rp_r + 1'b1;
          tx_cnt_nxt       = tx_cnt_r - 1'b1;
          resp.tx_valid    = 1'b1;
          resp.tx_from_mem = 1'b1;
        end
      end
      uartrb_pkg::CMD_HOST_WR: begin
        if (tx_cnt_r == TX_CNT_FULL) begin
          resp.status = uartrb_pkg::ST_WR_FULL;
        end else if (tx_cnt_r != '0 || !dre_empty) begin
          tx_req.we    = 1'b1;
          tx_req.addr  = tx_wp_r;
          tx_req.wdata = byte_in;
          tx_wp_nxt    = (tx_wp_r == TX_LAST) ? '0 : tx_wp_r + 1'b1;
          tx_cnt_nxt   = tx_cnt_r + 1'b1;
        end else begin
          // Empty queue and free data register: the byte goes straight out.
          resp.tx_valid = 1'b1;
          resp.tx_byte  = byte_in;
        end
      end
      uartrb_pkg::CMD_HOST_RD: begin
        if (rx_cnt_r == '0) begin
          resp.status = uartrb_pkg::ST_RD_EMPTY;
        end else begin
          rx_req.re       = 1'b1;
          rx_req.addr     = rx_rp_r;
          rx_rp_nxt       = (rx_rp_r == RX_LAST) ? '0 : rx_rp_r + 1'b1;
          rx_cnt_nxt      = rx_cnt_r - 1'b1;
          resp.read_valid = 1'b1;
        end
      end
    endcase

    resp.rx_overflow  = ovf_nxt;
    resp.rx_level     = uartrb_pkg::RX_LEVEL_W'(rx_cnt_nxt);
    resp.tx_level     = uartrb_pkg::TX_LEVEL_W'(tx_cnt_nxt);
    resp.rx_available = (rx_cnt_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wp_r  <= '0;
      rx_rp_r  <= '0;
      tx_wp_r  <= '0;
      tx_rp_r  <= '0;
      rx_cnt_r <= '0;
      tx_cnt_r <= '0;
      ovf_r    <= 1'b0;
    end else if (accept) begin
      rx_wp_r  <= rx_wp_nxt;
      rx_rp_r  <= rx_rp_nxt;
      tx_wp_r  <= tx_wp_nxt;
      tx_rp_r  <= tx_rp_nxt;
      rx_cnt_r <= rx_cnt_nxt;
      tx_cnt_r <= tx_cnt_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

@@ rtl/uart_rx_tx_ring_buffers_top.sv @@
// An accepted request is registered in the read stage, then in the output register (out_tvalid).
// Throughput: one request per cycle unless the output stalls; each one-port memory is used once.
// A stalled result holds in the output register while the next request waits in the read stage.
// Reset (rst_n low, synchronous) clears pointers, counts, the overflow flag and all valid bits.
// Buffer memories are not cleared; no clearing pass runs after reset.
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [7:0] byte_in, [10:8] line_errors, [11] dre_empty, [15:12] zero
  input  logic [uartrb_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] cmd
  input  logic [uartrb_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] read_valid, [17:10] read_byte, [19:18] status,
  // [20] rx_overflow, [26:21] rx_level, [33:27] tx_level, [34] rx_available,
  // [39:35] zero
  output logic [uartrb_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic                               accept;
  logic                               advance;
  uartrb_pkg::rx_req_t                rx_req;
  uartrb_pkg::tx_req_t                tx_req;
  uartrb_pkg::resp_t                  resp;
  logic [uartrb_pkg::BYTE_W-1:0]      rx_rdata, tx_rdata;

  logic                               s1_valid_r;
  uartrb_pkg::resp_t                  s1_r;
  logic                               out_valid_r;
  logic                               out_tx_valid_r;
  logic [uartrb_pkg::BYTE_W-1:0]      out_tx_byte_r;
  logic                               out_read_valid_r;
  logic [uartrb_pkg::BYTE_W-1:0]      out_read_byte_r;
  uartrb_pkg::status_t                out_status_r;
  logic                               out_ovf_r;
  logic [uartrb_pkg::RX_LEVEL_W-1:0]  out_rx_level_r;
  logic [uartrb_pkg::TX_LEVEL_W-1:0]  out_tx_level_r;
  logic                               out_rx_avail_r;

  // The read stage moves on whenever the output register is free or being drained.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  uartrb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (uartrb_pkg::cmd_e_t'(in_tuser)),
    .byte_in     (in_tdata[7:0]),
    .line_errors (in_tdata[10:8]),
    .dre_empty   (in_tdata[11]),
    .rx_req      (rx_req),
    .tx_req      (tx_req),
    .resp        (resp)
  );

  uartrb_ram #(
    .WIDTH (uartrb_pkg::BYTE_W),
    .DEPTH (uartrb_pkg::RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (accept && rx_req.we),
    .re    (accept && rx_req.re),
    .addr  (rx_req.addr),
    .wdata (rx_req.wdata),
    .rdata (rx_rdata)
  );

  uartrb_ram #(
    .WIDTH (uartrb_pkg::BYTE_W),
    .DEPTH (uartrb_pkg::TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (accept && tx_req.we),
    .re    (accept && tx_req.re),
    .addr  (tx_req.addr),
    .wdata (tx_req.wdata),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The memory read data stays put while the read stage stalls, since no
  // new request is taken until it moves on.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= resp;
    end
    if (advance) begin
      out_tx_valid_r   <= s1_r.tx_valid;
      out_tx_byte_r    <= s1_r.tx_from_mem ? tx_rdata : s1_r.tx_byte;
      out_read_valid_r <= s1_r.read_valid;
      out_read_byte_r  <= s1_r.read_valid ? rx_rdata : '0;
      out_status_r     <= s1_r.status;
      out_ovf_r        <= s1_r.rx_overflow;
      out_rx_level_r   <= s1_r.rx_level;
      out_tx_level_r   <= s1_r.tx_level;
      out_rx_avail_r   <= s1_r.rx_available;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_rx_avail_r, out_tx_level_r, out_rx_level_r, out_ovf_r,
                       out_status_r, out_read_byte_r, out_read_valid_r, out_tx_byte_r,
                       out_tx_valid_r};

`include "uart_rx_tx_ring_buffers_top_assert.svh"

  `UARTRB_ASSERT_NEXT(a_s1_held, s1_valid_r && !advance, s1_valid_r, "read stage lost a request")
  `UARTRB_ASSERT_NEXT(a_out_loaded, advance, out_valid_r, "output register missed a result")
  `UARTRB_ASSERT_NOW(a_read_ok, out_valid_r && out_read_valid_r, out_status_r == uartrb_pkg::ST_OK, "read returned with a refusal status")
  `UARTRB_ASSERT_NOW(a_rx_avail, out_valid_r, out_rx_avail_r == (out_rx_level_r != '0), "rx_available disagrees with rx_level")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import uartrb_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  // Response word as it leaves out_tdata, lowest field last.
  typedef struct packed {
    logic [4:0]            pad;
    logic                  rx_available;
    logic [TX_LEVEL_W-1:0] tx_level;
    logic [RX_LEVEL_W-1:0] rx_level;
    logic                  rx_overflow;
    status_t               status;
    logic [BYTE_W-1:0]     read_byte;
    logic                  read_valid;
    logic [BYTE_W-1:0]     tx_byte;
    logic                  tx_valid;
  } response_t;

  typedef enum int {
    MIX_ALL,
    MIX_FILL_RX,
    MIX_DRAIN_RX,
    MIX_FILL_TX,
    MIX_DRAIN_TX
  } traffic_mix_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of both ring buffers.
  logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
  logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
  int rx_wr = 0;
  int rx_rd = 0;
  int rx_fill = 0;
  int tx_wr = 0;
  int tx_rd = 0;
  int tx_fill = 0;
  logic rx_wrapped = 1'b0;

  response_t expected_responses[$];
  int mismatch_count = 0;
  int responses_seen = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  uart_rx_tx_ring_buffers_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic response_t predict_buffer_response(cmd_e_t cmd, logic [BYTE_W-1:0] data,
                                                        logic [ERR_W-1:0] errs, logic dre);
    response_t r;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_RX_BYTE: begin
        if (errs != 0) begin
          r.status = ST_DROP;
        end else begin
          rx_ring[rx_wr] = data;
          rx_wr = (rx_wr == RX_DEPTH - 1) ? 0 : rx_wr + 1;
          rx_fill++;
          // The count wraps instead of saturating; stored bytes stay but are lost to reads.
          if (rx_fill >= RX_DEPTH) begin
            rx_fill = 0;
            rx_wrapped = 1'b1;
          end
        end
      end
      CMD_TX_READY: begin
        if (tx_fill != 0) begin
          tx_fill--;
          r.tx_valid = 1'b1;
          r.tx_byte = tx_ring[tx_rd];
          tx_rd = (tx_rd == TX_DEPTH - 1) ? 0 : tx_rd + 1;
        end
      end
      CMD_HOST_WR: begin
        if (tx_fill >= TX_DEPTH) begin
          r.status = ST_WR_FULL;
        end else if (tx_fill != 0 || !dre) begin
          tx_ring[tx_wr] = data;
          tx_wr = (tx_wr == TX_DEPTH - 1) ? 0 : tx_wr + 1;
          tx_fill++;
        end else begin
          r.tx_valid = 1'b1;
          r.tx_byte = data;
        end
      end
      default: begin
        if (rx_fill == 0) begin
          r.status = ST_RD_EMPTY;
        end else begin
          r.read_valid = 1'b1;
          r.read_byte = rx_ring[rx_rd];
          rx_rd = (rx_rd == RX_DEPTH - 1) ? 0 : rx_rd + 1;
          rx_fill--;
        end
      end
    endcase
    r.rx_overflow = rx_wrapped;
    r.rx_level = rx_fill[RX_LEVEL_W-1:0];
    r.tx_level = tx_fill[TX_LEVEL_W-1:0];
    r.rx_available = (rx_fill != 0);
    return r;
  endfunction

  function automatic string describe_response(response_t r);
    return $sformatf("tx %b/%h rd %b/%h st %0d ovf %b rxl %0d txl %0d avail %b pad %h",
                     r.tx_valid, r.tx_byte, r.read_valid, r.read_byte, r.status,
                     r.rx_overflow, r.rx_level, r.tx_level, r.rx_available, r.pad);
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : check_responses
    response_t got;
    response_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = response_t'(out_tdata);
      responses_seen++;
      if (expected_responses.size() == 0) begin
        note_failure($sformatf("response %0d arrived with nothing expected: %s",
                               responses_seen, describe_response(got)));
      end else begin
        want = expected_responses.pop_front();
        if (got !== want) begin
          note_failure($sformatf("response %0d mismatch\n  expected %s\n  actual   %s",
                                 responses_seen, describe_response(want),
                                 describe_response(got)));
        end
      end
    end
  end

  // The receiver switches between stall patterns for stretches of random length.
  initial begin : drive_out_ready
    ready_mode_t mode;
    int stretch;
    int phase;
    out_tready = 1'b0;
    phase = 0;
    forever begin
      mode = ready_mode_t'($urandom_range(0, 3));
      stretch = $urandom_range(10, 120);
      repeat (stretch) begin
        @(negedge clk);
        phase++;
        case (mode)
          RDY_ALWAYS:   out_tready = 1'b1;
          RDY_RANDOM:   out_tready = ($urandom_range(0, 3) != 0);
          RDY_SPARSE:   out_tready = ($urandom_range(0, 3) == 0);
          RDY_PERIODIC: out_tready = ((phase % 9) >= 5);
          default:      out_tready = 1'b1;
        endcase
      end
    end
  end

  // Sends one request, inserting a random gap at the start of each burst.
  task automatic send_request(input cmd_e_t cmd, input logic [BYTE_W-1:0] data,
                              input logic [ERR_W-1:0] errs, input logic dre);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {{(IN_TDATA_W - 12){1'b0}}, dre, errs, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_responses.push_back(predict_buffer_response(cmd, data, errs, dre));
    items_sent++;
  endtask

  task automatic wait_for_responses();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input traffic_mix_t mix);
    int pick;
    cmd_e_t cmd;
    logic [ERR_W-1:0] errs;
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_FILL_RX:  cmd = (pick < 80) ? CMD_RX_BYTE : (pick < 90) ? CMD_HOST_RD :
                          cmd_e_t'($urandom_range(1, 2));
      MIX_DRAIN_RX: cmd = (pick < 70) ? CMD_HOST_RD : (pick < 85) ? CMD_RX_BYTE :
                          cmd_e_t'($urandom_range(1, 2));
      MIX_FILL_TX:  cmd = (pick < 80) ? CMD_HOST_WR : (pick < 90) ? CMD_TX_READY :
                          ((pick < 95) ? CMD_RX_BYTE : CMD_HOST_RD);
      MIX_DRAIN_TX: cmd = (pick < 70) ? CMD_TX_READY : (pick < 85) ? CMD_HOST_WR :
                          ((pick < 92) ? CMD_RX_BYTE : CMD_HOST_RD);
      default:      cmd = cmd_e_t'($urandom_range(0, 3));
    endcase
    // Received bytes are mostly clean so the receive queue actually fills.
    if (cmd == CMD_RX_BYTE)
      errs = ($urandom_range(0, 7) == 0) ? ERR_W'($urandom_range(1, 7)) : '0;
    else
      errs = ERR_W'($urandom_range(0, 7));
    send_request(cmd, BYTE_W'($urandom_range(0, 255)), errs, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed_cases();
    send_request(CMD_HOST_RD,  8'h00, 3'd0, 1'b0);
    send_request(CMD_TX_READY, 8'hFF, 3'd7, 1'b1);
    send_request(CMD_RX_BYTE,  8'h00, 3'd0, 1'b0);
    send_request(CMD_RX_BYTE,  8'hFF, 3'd1, 1'b0);
    send_request(CMD_RX_BYTE,  8'hA5, 3'd2, 1'b1);
    send_request(CMD_RX_BYTE,  8'h5A, 3'd4, 1'b0);
    send_request(CMD_RX_BYTE,  8'hFF, 3'd7, 1'b1);
    send_request(CMD_RX_BYTE,  8'hFF, 3'd0, 1'b1);
    send_request(CMD_HOST_RD,  8'hFF, 3'd7, 1'b1);
    send_request(CMD_HOST_RD,  8'h00, 3'd0, 1'b0);
    send_request(CMD_HOST_RD,  8'h00, 3'd0, 1'b0);
    send_request(CMD_HOST_WR,  8'hFF, 3'd0, 1'b1);
    send_request(CMD_HOST_WR,  8'h00, 3'd7, 1'b0);
    send_request(CMD_HOST_WR,  8'h81, 3'd0, 1'b1);
    send_request(CMD_TX_READY, 8'h00, 3'd0, 1'b0);
    send_request(CMD_TX_READY, 8'h00, 3'd0, 1'b0);
    send_request(CMD_TX_READY, 8'h00, 3'd0, 1'b0);
    send_request(CMD_HOST_WR,  8'h3C, 3'd5, 1'b1);
  endtask

  task automatic test_rx_overflow_wrap();
    // Clean bytes go in until the count wraps, with an occasional dropped byte in between.
    do begin
      if ($urandom_range(0, 9) == 0)
        send_request(CMD_RX_BYTE, BYTE_W'($urandom_range(0, 255)),
                     ERR_W'($urandom_range(1, 7)), 1'b0);
      send_request(CMD_RX_BYTE, BYTE_W'($urandom_range(0, 255)), 3'd0,
                   1'($urandom_range(0, 1)));
    end while (rx_fill != 0);
    repeat (2) send_request(CMD_HOST_RD, 8'h00, 3'd0, 1'b0);
    repeat (3) send_request(CMD_RX_BYTE, BYTE_W'($urandom_range(0, 255)), 3'd0, 1'b0);
    repeat (4) send_request(CMD_HOST_RD, 8'h00, 3'd0, 1'b0);
  endtask

  task automatic test_tx_queue_full();
    while (tx_fill < TX_DEPTH)
      send_request(CMD_HOST_WR, BYTE_W'($urandom_range(0, 255)), 3'd0,
                   1'($urandom_range(0, 1)));
    repeat (3) send_request(CMD_HOST_WR, BYTE_W'($urandom_range(0, 255)), 3'd0, 1'b1);
    while (tx_fill != 0) send_request(CMD_TX_READY, 8'h00, 3'd0, 1'b0);
    send_request(CMD_TX_READY, 8'h00, 3'd0, 1'b0);
  endtask

  task automatic test_random_traffic();
    traffic_mix_t mix;
    int len;
    while (items_sent < ITEM_TARGET) begin
      mix = traffic_mix_t'($urandom_range(0, 4));
      len = $urandom_range(8, 90);
      repeat (len) send_random(mix);
      if ($urandom_range(0, 7) == 0) wait_for_responses();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_RX_BYTE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_rx_overflow_wrap();
    test_tx_queue_full();
    // Hold off the sender entirely until the pipeline has emptied.
    wait_for_responses();
    test_random_traffic();

    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0)
      note_failure($sformatf("%0d responses never arrived", expected_responses.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/uartrb_pkg.sv
rtl/uartrb_ram.sv
rtl/uartrb_ctrl.sv
rtl/uart_rx_tx_ring_buffers_top.sv
verif/testbench.sv
